// ===== design/md4_message_digest_assert.svh =====
// assertion macros for the md4 digest block
`ifndef MD4_MESSAGE_DIGEST_ASSERT_SVH
`define MD4_MESSAGE_DIGEST_ASSERT_SVH

`ifndef SYNTHESIS
`define MD4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("md4 assertion failed");
`define MD4_ASSERT_NEXT(lbl, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) \
    else $error("md4 assertion failed");
`else
`define MD4_ASSERT(lbl, prop)
`define MD4_ASSERT_NEXT(lbl, cond, res)
`endif

`endif

// ===== design/md4_pkg.sv =====
`timescale 1ns / 1ps

package md4_pkg;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] K1 = 32'h5A827999;
  localparam logic [31:0] K2 = 32'h6ED9EBA1;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LastStep = 6'd47;
  localparam logic [3:0] LastWord = 4'd15;
  localparam logic [3:0] LenLoWord = 4'd14;
  localparam logic [2:0] FullBytes = 3'd4;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  typedef struct packed {
    logic done;
  } core_sts_t;

  typedef logic [3:0][31:0] chain_t;

  // message word used by a given step
  function automatic logic [3:0] word_index(input logic [5:0] step);
    logic [3:0] idx;
    case (step[5:4])
      2'd0: begin
        idx = step[3:0];
      end
      2'd1: begin
        idx = {step[1:0], step[3:2]};
      end
      default: begin
        idx = {step[0], step[1], step[2], step[3]};
      end
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] step);
    logic [4:0] s;
    case ({step[5:4], step[1:0]})
      4'd0: s = 5'd3;
      4'd1: s = 5'd7;
      4'd2: s = 5'd11;
      4'd3: s = 5'd19;
      4'd4: s = 5'd3;
      4'd5: s = 5'd5;
      4'd6: s = 5'd9;
      4'd7: s = 5'd13;
      4'd8: s = 5'd3;
      4'd9: s = 5'd9;
      4'd10: s = 5'd11;
      4'd11: s = 5'd15;
      default: s = 5'd3;
    endcase
    return s;
  endfunction

endpackage

// ===== design/md4_msgbuf.sv =====
`timescale 1ns / 1ps

module md4_msgbuf (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_idx,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_idx,
  output logic [31:0] rd_data
);

  logic [31:0] words [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= words[rd_idx];
  end

endmodule

// ===== design/md4_core.sv =====
`timescale 1ns / 1ps

module md4_core import md4_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  core_ctl_t   ctl,
  output core_sts_t   sts,
  output logic [3:0]  rd_idx,
  input  logic [31:0] rd_data,
  output chain_t      chain
);

  logic [31:0] a, b, c, d;
  logic [5:0]  step;
  logic        running;
  logic        fin;
  logic [31:0] f, k, t;
  logic [63:0] rot;

  // one md4 step per cycle
  always_comb begin
    case (step[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        k = 32'd0;
      end
      2'd1: begin
        f = (b & c) | (b & d) | (c & d);
        k = K1;
      end
      default: begin
        f = b ^ c ^ d;
        k = K2;
      end
    endcase
    t = a + f + rd_data + k;
    rot = {t, t} << rot_amount(step);
  end

  // message word for the coming step, read in the cycle before that step runs
  assign rd_idx = word_index(running ? step + 6'd1 : 6'd0);
  assign sts.done = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin <= 1'b0;
      chain <= {Iv3, Iv2, Iv1, Iv0};
    end else begin
      if (ctl.init) begin
        chain <= {Iv3, Iv2, Iv1, Iv0};
      end
      if (ctl.start) begin
        running <= 1'b1;
      end else if (running) begin
        if (step == LastStep) begin
          running <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin <= 1'b0;
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      step <= 6'd0;
    end else if (running) begin
      a <= d;
      d <= c;
      c <= b;
      b <= rot[63:32];
      step <= step + 6'd1;
    end
  end

endmodule

// ===== design/md4_message_digest.sv =====
`timescale 1ns / 1ps

// MD4 digest of a byte message fed as 32-bit little-endian words, first byte
// in bits 7 to 0. Each non-final word is taken while the block is idle; the
// word that fills a 64-byte block then holds the input off for the compression
// (48 steps on the one shared round unit plus the chaining add). The final
// word (0 to 4 valid bytes) is followed by the padding words and one or two
// more compressions; the digest then sits in an output register and a new
// message may start while it waits.

module md4_message_digest import md4_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_low,
  output logic [63:0] digest_high
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_COMP = 4'b0010,
    S_PAD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t      state, state_next;
  core_ctl_t   ctl;
  core_sts_t   sts;
  chain_t      chain;
  logic [3:0]  rd_idx;
  logic [31:0] rd_data;
  logic        wr_en;
  logic [31:0] wr_data;
  logic [3:0]  wptr;
  logic [60:0] count;
  logic        need80, lo_done, padding, fin_blk;
  logic        accept, load_out;
  logic [2:0]  nv;
  logic [31:0] last_data;
  logic [63:0] bits;

  assign in_ready = !rst && (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign nv = !last_word ? FullBytes : (valid_bytes > FullBytes) ? FullBytes : valid_bytes;
  assign bits = {count, 3'b000};
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // keep valid bytes, put the pad marker right after them
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < nv) begin
        last_data[8*j +: 8] = data_word[8*j +: 8];
      end else if (3'(j) == nv) begin
        last_data[8*j +: 8] = PadByte;
      end else begin
        last_data[8*j +: 8] = 8'd0;
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_data = 32'd0;
    ctl.start = 1'b0;
    ctl.init = load_out;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          wr_en = 1'b1;
          wr_data = last_data;
          if (wptr == LastWord) begin
            ctl.start = 1'b1;
            state_next = S_COMP;
          end else if (last_word) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        wr_en = 1'b1;
        if (need80) begin
          wr_data = {24'd0, PadByte};
        end else if (wptr == LenLoWord) begin
          wr_data = bits[31:0];
        end else if (wptr == LastWord && lo_done) begin
          wr_data = bits[63:32];
        end
        if (wptr == LastWord) begin
          ctl.start = 1'b1;
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        if (sts.done) begin
          if (!padding) begin
            state_next = S_IDLE;
          end else if (fin_blk) begin
            state_next = S_DONE;
          end else begin
            state_next = S_PAD;
          end
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr <= 4'd0;
      count <= 61'd0;
      need80 <= 1'b0;
      lo_done <= 1'b0;
      padding <= 1'b0;
      fin_blk <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        wptr <= wptr + 4'd1;
      end
      if (accept) begin
        count <= count + 61'(nv);
        need80 <= last_word && (nv == FullBytes);
        padding <= last_word;
        lo_done <= 1'b0;
      end
      if (state == S_PAD) begin
        if (need80) begin
          need80 <= 1'b0;
          lo_done <= 1'b0;
        end else if (wptr == LenLoWord) begin
          lo_done <= 1'b1;
        end else if (wptr == LastWord && lo_done) begin
          fin_blk <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
        count <= 61'd0;
        padding <= 1'b0;
        fin_blk <= 1'b0;
        lo_done <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      digest_low <= {chain[1], chain[0]};
      digest_high <= {chain[3], chain[2]};
    end
  end

  md4_msgbuf u_msgbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wptr),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  md4_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sts     (sts),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .chain   (chain)
  );

`include "md4_message_digest_assert.svh"

  `MD4_ASSERT_NEXT(a_start_wraps, ctl.start, wptr == 4'd0)
  `MD4_ASSERT(a_done_in_comp, sts.done |-> state == S_COMP)
  `MD4_ASSERT(a_done_aligned, state == S_DONE |-> padding && fin_blk && wptr == 4'd0)

endmodule
